FILE: hdl/cantx_pkg.sv
`timescale 1ns / 1ps

package cantx_pkg;

    localparam int FIRST_SLOT_DEF    = 16;
    localparam int CALLBACK_SLOT_DEF = 31;

    localparam int SLOT_COUNT = 16;
    localparam int ENTRY_W    = 4;
    localparam int IDX_W      = 5;
    localparam int ID_W       = 29;
    localparam int STD_ID_W   = 11;
    localparam int CNT_W      = 4;

    localparam logic [CNT_W-1:0] APP_TX_COUNT_RST = 4'd15;

    localparam logic [1:0] MODE_REQUEST = 2'd0;
    localparam logic [1:0] MODE_LOAD    = 2'd1;
    localparam logic [1:0] MODE_FINISH  = 2'd2;
    localparam logic [1:0] MODE_MUTE    = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_READ = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    typedef struct packed {
        logic [IDX_W-1:0] chosen;
        logic             found;
        logic             status;
    } result_t;

endpackage

FILE: hdl/can_tx_mailbox_allocator.sv
`timescale 1ns / 1ps

// Transmit mailbox allocator for a CAN controller. Each input beat carries one
// operation (request, load, send finished, mute) and produces exactly one result
// beat. Load, send finished, mute and callback requests go from acceptance
// straight to the result register. A normal request scans the mailboxes from
// the top pointer down to FIRST_SLOT, one mailbox per cycle, and ends early when
// it meets a busy mailbox with the same identifier. The identifier memory has a
// single registered read port. One operation is in flight at a time; the result
// register lets the next beat be accepted in the cycle after the result is handed
// over, even before it is taken. Busy flags live in flip-flops and clear at reset
// and on mute; identifiers are only read for busy mailboxes, so the memory needs
// no clearing pass.
module can_tx_mailbox_allocator #(
    parameter int FIRST_SLOT    = cantx_pkg::FIRST_SLOT_DEF,
    parameter int CALLBACK_SLOT = cantx_pkg::CALLBACK_SLOT_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            cfg_wr_en,
    input  logic [cantx_pkg::CNT_W-1:0]     cfg_wr_data,

    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [1:0]                      s_mode,
    input  logic [cantx_pkg::ID_W-1:0]      s_frame_id,
    input  logic                            s_frame_extended,
    input  logic                            s_use_callback_slot,
    input  logic [cantx_pkg::IDX_W-1:0]     s_mailbox_index,

    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [cantx_pkg::IDX_W-1:0]     m_chosen_mailbox,
    output logic                            m_mailbox_found,
    output logic                            m_status
);

    localparam int ENTRY_W = cantx_pkg::ENTRY_W;
    localparam int IDX_W   = cantx_pkg::IDX_W;
    localparam int ID_W    = cantx_pkg::ID_W;
    localparam int CNT_W   = cantx_pkg::CNT_W;
    localparam int SLOTS   = cantx_pkg::SLOT_COUNT;
    localparam int WORD_W  = ID_W + 1;

    localparam logic [IDX_W-1:0]   FIRST5   = IDX_W'(FIRST_SLOT);
    localparam logic [IDX_W:0]     FIRST6   = (IDX_W+1)'(FIRST_SLOT);
    localparam logic [IDX_W-1:0]   CB5      = IDX_W'(CALLBACK_SLOT);
    localparam logic [ENTRY_W-1:0] CB_ENTRY = ENTRY_W'((CALLBACK_SLOT - FIRST_SLOT) & (SLOTS - 1));
    localparam logic [IDX_W-1:0]   MAX_IDX  = {IDX_W{1'b1}};
    localparam logic [IDX_W:0]     SLOTS6   = (IDX_W+1)'(SLOTS);

    function automatic logic [ENTRY_W-1:0] entry_of(input logic [IDX_W-1:0] m);
        logic [IDX_W-1:0] d;
        d = m - FIRST5;
        return d[ENTRY_W-1:0];
    endfunction

    // identifier and format per mailbox
    logic [WORD_W-1:0] mem [SLOTS];
    logic [WORD_W-1:0] rd_data_reg;
    logic [ENTRY_W-1:0] rd_addr;
    logic               mem_we;
    logic [ENTRY_W-1:0] mem_waddr;
    logic [WORD_W-1:0]  mem_wdata;

    cantx_pkg::state_t   state_reg, state_next;
    logic [SLOTS-1:0]    busy_reg, busy_next;
    logic [IDX_W-1:0]    top_slot_reg, top_slot_next;
    logic [CNT_W-1:0]    app_cnt_reg, app_cnt_next;
    logic [IDX_W-1:0]    scan_i_reg, scan_i_next;
    logic                busy_seen_reg, busy_seen_next;
    logic                free_found_reg, free_found_next;
    logic [IDX_W-1:0]    free_slot_reg, free_slot_next;
    logic [ID_W-1:0]     id_reg, id_next;
    logic                ext_reg, ext_next;
    cantx_pkg::result_t  res_reg, res_next;
    logic                m_valid_reg, m_valid_next;
    cantx_pkg::result_t  m_res_reg, m_res_next;

    logic               s_fire;
    logic [ENTRY_W-1:0] s_entry;
    logic               s_in_store;
    logic               s_in_app;
    logic               load_ok;
    logic [ENTRY_W-1:0] scan_entry;
    logic               scan_busy;
    logic               scan_hit;
    logic               scan_last;
    logic               fin_free;
    logic [IDX_W-1:0]   fin_slot;
    logic               grow_ok;

    assign s_ready = (state_reg == cantx_pkg::ST_IDLE);
    assign s_fire  = s_valid && s_ready;

    assign s_entry    = entry_of(s_mailbox_index);
    assign s_in_store = (s_mailbox_index >= FIRST5) &&
                        (({1'b0, s_mailbox_index} - FIRST6) < SLOTS6);
    assign s_in_app   = (s_mailbox_index >= FIRST5) &&
                        ({1'b0, s_mailbox_index} < (FIRST6 + {2'b00, app_cnt_reg}));
    assign load_ok    = (s_in_app || (s_mailbox_index == CB5)) && s_in_store &&
                        !busy_reg[s_entry];

    assign scan_entry = entry_of(scan_i_reg);
    assign scan_busy  = busy_reg[scan_entry];
    assign scan_hit   = scan_busy && (rd_data_reg[ID_W-1:0] == id_reg) &&
                        (rd_data_reg[ID_W] == ext_reg);
    assign scan_last  = scan_hit || (scan_i_reg == FIRST5);
    assign fin_free   = free_found_reg || !scan_busy;
    assign fin_slot   = scan_busy ? free_slot_reg : scan_i_reg;
    assign grow_ok    = (top_slot_reg != MAX_IDX) &&
                        (({1'b0, top_slot_reg} + 6'd1) < (FIRST6 + {2'b00, app_cnt_reg}));

    assign rd_addr = (state_reg == cantx_pkg::ST_READ) ? entry_of(top_slot_reg)
                                                       : entry_of(scan_i_reg - 5'd1);

    always_comb begin
        state_next      = state_reg;
        busy_next       = busy_reg;
        top_slot_next   = top_slot_reg;
        app_cnt_next    = cfg_wr_en ? cfg_wr_data : app_cnt_reg;
        scan_i_next     = scan_i_reg;
        busy_seen_next  = busy_seen_reg;
        free_found_next = free_found_reg;
        free_slot_next  = free_slot_reg;
        id_next         = id_reg;
        ext_next        = ext_reg;
        res_next        = res_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_res_next      = m_res_reg;
        mem_we          = 1'b0;
        mem_waddr       = s_entry;
        mem_wdata       = s_frame_extended ? {1'b1, s_frame_id}
                        : {1'b0, {(ID_W-cantx_pkg::STD_ID_W){1'b0}},
                           s_frame_id[cantx_pkg::STD_ID_W-1:0]};

        unique case (state_reg)
            cantx_pkg::ST_IDLE: begin
                if (s_fire) begin
                    id_next    = s_frame_id;
                    ext_next   = s_frame_extended;
                    res_next   = '0;
                    state_next = cantx_pkg::ST_DONE;
                    unique case (s_mode)
                        cantx_pkg::MODE_REQUEST: begin
                            if (s_use_callback_slot) begin
                                res_next.found  = !busy_reg[CB_ENTRY];
                                res_next.chosen = busy_reg[CB_ENTRY] ? '0 : CB5;
                            end else begin
                                state_next = cantx_pkg::ST_READ;
                            end
                        end
                        cantx_pkg::MODE_LOAD: begin
                            if (load_ok) begin
                                mem_we             = 1'b1;
                                busy_next[s_entry] = 1'b1;
                            end
                            res_next.status = !load_ok;
                        end
                        cantx_pkg::MODE_FINISH: begin
                            if (s_in_store) begin
                                busy_next[s_entry] = 1'b0;
                            end
                        end
                        cantx_pkg::MODE_MUTE: begin
                            busy_next = '0;
                        end
                        default: ;
                    endcase
                end
            end
            cantx_pkg::ST_READ: begin
                scan_i_next     = top_slot_reg;
                busy_seen_next  = 1'b0;
                free_found_next = 1'b0;
                free_slot_next  = '0;
                state_next      = cantx_pkg::ST_SCAN;
            end
            cantx_pkg::ST_SCAN: begin
                if (!scan_busy) begin
                    free_found_next = 1'b1;
                    free_slot_next  = scan_i_reg;
                    // lower the top pointer only across the idle run at the top
                    if (!busy_seen_reg) begin
                        top_slot_next = scan_i_reg;
                    end
                end else begin
                    busy_seen_next = 1'b1;
                end
                if (scan_last) begin
                    state_next = cantx_pkg::ST_DONE;
                    if (fin_free) begin
                        res_next.found  = 1'b1;
                        res_next.chosen = fin_slot;
                    end else if (grow_ok) begin
                        // nothing idle: open one more mailbox above the top
                        top_slot_next   = top_slot_reg + 5'd1;
                        res_next.found  = 1'b1;
                        res_next.chosen = top_slot_reg + 5'd1;
                    end
                end else begin
                    scan_i_next = scan_i_reg - 5'd1;
                end
            end
            cantx_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_res_next   = res_reg;
                    state_next   = cantx_pkg::ST_IDLE;
                end
            end
            default: state_next = cantx_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= cantx_pkg::ST_IDLE;
            busy_reg     <= '0;
            top_slot_reg <= FIRST5;
            app_cnt_reg  <= cantx_pkg::APP_TX_COUNT_RST;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            busy_reg     <= busy_next;
            top_slot_reg <= top_slot_next;
            app_cnt_reg  <= app_cnt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_i_reg     <= scan_i_next;
        busy_seen_reg  <= busy_seen_next;
        free_found_reg <= free_found_next;
        free_slot_reg  <= free_slot_next;
        id_reg         <= id_next;
        ext_reg        <= ext_next;
        res_reg        <= res_next;
        m_res_reg      <= m_res_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_chosen_mailbox = m_res_reg.chosen;
    assign m_mailbox_found  = m_res_reg.found;
    assign m_status         = m_res_reg.status;

    a_top_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        top_slot_reg >= FIRST5)
        else $error("top pointer fell below the first transmit mailbox");

    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == cantx_pkg::ST_SCAN) |-> (scan_i_reg >= FIRST5))
        else $error("scan index left the transmit mailbox range");

    a_no_grant_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_res_reg.found) |-> (m_res_reg.chosen == '0))
        else $error("result without a grant carries a mailbox index");

    a_status_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_res_reg.status) |-> !m_res_reg.found)
        else $error("failed load reported as a grant");

    a_result_handover: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == cantx_pkg::ST_DONE && (!m_valid_reg || m_ready)) |=>
            (m_valid_reg && state_reg == cantx_pkg::ST_IDLE))
        else $error("finished result not moved to the output register");

endmodule

FILE: sim/can_tx_mailbox_allocator_test.sv
`timescale 1ns / 1ps

module can_tx_mailbox_allocator_test;
    import cantx_pkg::*;

    localparam int FIRST_SLOT    = FIRST_SLOT_DEF;
    localparam int CALLBACK_SLOT = CALLBACK_SLOT_DEF;
    localparam logic [ENTRY_W-1:0] CB_ENTRY = ENTRY_W'(CALLBACK_SLOT - FIRST_SLOT);

    typedef struct packed {
        logic [1:0]       mode;
        logic [ID_W-1:0]  frame_id;
        logic             ext;
        logic             use_cb;
        logic [IDX_W-1:0] idx;
    } mbox_op_t;

    typedef struct packed {
        logic [CNT_W-1:0]                     count;
        logic [SLOT_COUNT-1:0]                busy;
        logic [SLOT_COUNT-1:0][ID_W-1:0]      ident;
        logic [SLOT_COUNT-1:0]                ext;
        logic [IDX_W-1:0]                     top;
    } alloc_state_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [CNT_W-1:0]    cfg_wr_data = '0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [1:0]          s_mode = MODE_REQUEST;
    logic [ID_W-1:0]     s_frame_id = '0;
    logic                s_frame_extended = 1'b0;
    logic                s_use_callback_slot = 1'b0;
    logic [IDX_W-1:0]    s_mailbox_index = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [IDX_W-1:0]    m_chosen_mailbox;
    logic                m_mailbox_found;
    logic                m_status;

    mbox_op_t     pending_ops[$];
    result_t      expected_grants[$];
    alloc_state_t alloc_model;
    alloc_state_t plan_model;
    int           errors = 0;
    int           beats_seen = 0;
    bit           in_fire = 1'b0;
    bit           steady = 1'b0;

    can_tx_mailbox_allocator dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_mode             (s_mode),
        .s_frame_id         (s_frame_id),
        .s_frame_extended   (s_frame_extended),
        .s_use_callback_slot(s_use_callback_slot),
        .s_mailbox_index    (s_mailbox_index),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_chosen_mailbox   (m_chosen_mailbox),
        .m_mailbox_found    (m_mailbox_found),
        .m_status           (m_status)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic alloc_state_t alloc_reset_state();
        alloc_state_t st;
        st = '0;
        st.count = APP_TX_COUNT_RST;
        st.top = IDX_W'(FIRST_SLOT);
        return st;
    endfunction

    // Apply one operation to the mailbox state and return the result beat.
    function automatic result_t predict_grant(inout alloc_state_t st, input mbox_op_t op);
        result_t          r;
        int               i;
        int               lowest;
        int               last_app;
        int               mbox;
        logic             busy_seen;
        logic             in_store;
        logic             load_ok;
        logic [ENTRY_W-1:0] e;
        r = '0;
        mbox = int'(op.idx);
        e = ENTRY_W'(mbox - FIRST_SLOT);
        in_store = (mbox >= FIRST_SLOT) && (mbox - FIRST_SLOT < SLOT_COUNT);
        case (op.mode)
            MODE_REQUEST: begin
                if (op.use_cb) begin
                    if (!st.busy[CB_ENTRY]) begin
                        r.chosen = IDX_W'(CALLBACK_SLOT);
                        r.found = 1'b1;
                    end
                end else begin
                    lowest = -1;
                    busy_seen = 1'b0;
                    for (i = int'(st.top); i >= FIRST_SLOT; i--) begin
                        e = ENTRY_W'(i - FIRST_SLOT);
                        if (!st.busy[e]) begin
                            lowest = i;
                            if (!busy_seen) st.top = IDX_W'(i);
                        end else begin
                            busy_seen = 1'b1;
                            // same frame already queued: nothing below may overtake it
                            if (st.ident[e] == op.frame_id && st.ext[e] == op.ext) break;
                        end
                    end
                    last_app = FIRST_SLOT + int'(st.count) - 1;
                    if (last_app > 31) last_app = 31;
                    if (lowest < 0 && int'(st.top) < last_app) begin
                        st.top = st.top + 1'b1;
                        lowest = int'(st.top);
                    end
                    if (lowest >= 0) begin
                        r.chosen = IDX_W'(lowest);
                        r.found = 1'b1;
                    end
                end
            end
            MODE_LOAD: begin
                load_ok = ((mbox >= FIRST_SLOT && mbox < FIRST_SLOT + int'(st.count)) ||
                           mbox == CALLBACK_SLOT) && in_store && !st.busy[e];
                if (load_ok) begin
                    st.ident[e] = op.ext ? op.frame_id : {{(ID_W-STD_ID_W){1'b0}},
                                                          op.frame_id[STD_ID_W-1:0]};
                    st.ext[e] = op.ext;
                    st.busy[e] = 1'b1;
                end else begin
                    r.status = 1'b1;
                end
            end
            MODE_FINISH: begin
                if (in_store) st.busy[e] = 1'b0;
            end
            default: begin
                st.busy = '0;
            end
        endcase
        return r;
    endfunction

    function automatic mbox_op_t make_op(input logic [1:0] mode, input logic [ID_W-1:0] id,
                                         input logic ext, input logic cb,
                                         input logic [IDX_W-1:0] idx);
        mbox_op_t op;
        op.mode = mode;
        op.frame_id = id;
        op.ext = ext;
        op.use_cb = cb;
        op.idx = idx;
        return op;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        $display("mismatch on %s at result beat %0d: got %0d, want %0d",
                 what, beats_seen, got, want);
    endtask

    // Driver: hold the beat until accepted, then advance or idle.
    always @(negedge aclk) begin : drive_input
        mbox_op_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_fire) begin
            if (pending_ops.size() > 0 && (steady || $urandom_range(0, 99) >= 34)) begin
                nxt = pending_ops.pop_front();
                s_valid <= 1'b1;
                s_mode <= nxt.mode;
                s_frame_id <= nxt.frame_id;
                s_frame_extended <= nxt.ext;
                s_use_callback_slot <= nxt.use_cb;
                s_mailbox_index <= nxt.idx;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else m_ready <= steady || ($urandom_range(0, 99) >= 34);
    end

    // Predict on each accepted beat, check each delivered beat.
    always @(posedge aclk) begin : track_beats
        result_t want;
        in_fire = aresetn && s_valid && s_ready;
        if (in_fire) begin
            want = predict_grant(alloc_model, make_op(s_mode, s_frame_id, s_frame_extended,
                                                      s_use_callback_slot, s_mailbox_index));
            expected_grants.push_back(want);
        end
        if (aresetn && m_valid && m_ready) begin
            beats_seen++;
            if (expected_grants.size() == 0) begin
                report_mismatch("unexpected result beat", m_chosen_mailbox, -1);
            end else begin
                want = expected_grants.pop_front();
                if (m_chosen_mailbox !== want.chosen)
                    report_mismatch("chosen_mailbox", m_chosen_mailbox, want.chosen);
                if (m_mailbox_found !== want.found)
                    report_mismatch("mailbox_found", m_mailbox_found, want.found);
                if (m_status !== want.status)
                    report_mismatch("status", m_status, want.status);
            end
        end
    end

    task automatic issue(input mbox_op_t op, output result_t r);
        r = predict_grant(plan_model, op);
        pending_ops.push_back(op);
    endtask

    task automatic drain();
        while (pending_ops.size() != 0 || s_valid || expected_grants.size() != 0)
            @(posedge aclk);
    endtask

    task automatic set_app_count(input logic [CNT_W-1:0] v);
        drain();
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        alloc_model.count = v;
        plan_model.count = v;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_random(input int n);
        int              issued;
        int              pick;
        int              i;
        int              busy_list[$];
        logic [ID_W-1:0] id;
        logic [ID_W-1:0] last_id;
        logic            ext;
        logic            last_ext;
        logic            cb;
        result_t         r;
        issued = 0;
        last_id = '0;
        last_ext = 1'b0;
        while (issued < n) begin
            pick = $urandom_range(0, 99);
            ext = 1'($urandom_range(0, 1));
            id = ID_W'($urandom);
            if (!ext && $urandom_range(0, 3) != 0) id = id & ID_W'(11'h7FF);
            if ($urandom_range(0, 2) == 0) begin
                id = last_id;
                ext = last_ext;
            end
            cb = ($urandom_range(0, 9) == 0);
            if (pick < 45) begin
                // request then load the granted mailbox with the same frame
                issue(make_op(MODE_REQUEST, id, ext, cb, IDX_W'($urandom_range(0, 31))), r);
                issued++;
                if (r.found) begin
                    issue(make_op(MODE_LOAD, id, ext, 1'($urandom_range(0, 1)), r.chosen), r);
                    issued++;
                end
                last_id = id;
                last_ext = ext;
            end else if (pick < 75) begin
                busy_list.delete();
                for (i = 0; i < SLOT_COUNT; i++)
                    if (plan_model.busy[i]) busy_list.push_back(FIRST_SLOT + i);
                if (busy_list.size() > 0)
                    i = busy_list[$urandom_range(0, busy_list.size() - 1)];
                else
                    i = $urandom_range(0, 31);
                issue(make_op(MODE_FINISH, id, ext, cb, IDX_W'(i)), r);
                issued++;
            end else if (pick < 87) begin
                issue(make_op(MODE_REQUEST, id, ext, cb, IDX_W'($urandom_range(0, 31))), r);
                issued++;
            end else if (pick < 90) begin
                issue(make_op(MODE_MUTE, id, ext, cb, IDX_W'($urandom_range(0, 31))), r);
                issued++;
            end else begin
                issue(make_op(2'($urandom_range(0, 3)), ID_W'($urandom),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              IDX_W'($urandom_range(0, 31))), r);
                issued++;
            end
        end
    endtask

    initial begin : stimulus
        result_t r;
        alloc_model = alloc_reset_state();
        plan_model = alloc_reset_state();
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: grants, same-frame ordering, range and busy failures, masking
        issue(make_op(MODE_REQUEST, 29'h7FF, 1'b0, 1'b0, 5'd0), r);
        issue(make_op(MODE_LOAD, 29'h7FF, 1'b0, 1'b0, 5'd16), r);
        issue(make_op(MODE_REQUEST, 29'h7FF, 1'b0, 1'b0, 5'd0), r);
        issue(make_op(MODE_LOAD, 29'h7FF, 1'b0, 1'b0, 5'd17), r);
        issue(make_op(MODE_LOAD, 29'h0, 1'b0, 1'b0, 5'd17), r);
        issue(make_op(MODE_REQUEST, 29'h0, 1'b0, 1'b1, 5'd0), r);
        issue(make_op(MODE_LOAD, 29'h1FFFFFFF, 1'b1, 1'b1, 5'd31), r);
        issue(make_op(MODE_LOAD, 29'h1FFFFFFF, 1'b1, 1'b1, 5'd31), r);
        issue(make_op(MODE_REQUEST, 29'h1FFFFFFF, 1'b1, 1'b1, 5'd31), r);
        issue(make_op(MODE_LOAD, 29'h1, 1'b0, 1'b0, 5'd0), r);
        issue(make_op(MODE_LOAD, 29'h1, 1'b0, 1'b0, 5'd15), r);
        issue(make_op(MODE_FINISH, 29'h0, 1'b0, 1'b0, 5'd0), r);
        issue(make_op(MODE_FINISH, 29'h0, 1'b0, 1'b0, 5'd31), r);
        issue(make_op(MODE_REQUEST, 29'h1FFFFFFF, 1'b0, 1'b0, 5'd0), r);
        issue(make_op(MODE_LOAD, 29'h1FFFFFFF, 1'b0, 1'b0, r.chosen), r);
        issue(make_op(MODE_REQUEST, 29'h1FFFFFFF, 1'b0, 1'b0, 5'd0), r);
        issue(make_op(MODE_REQUEST, 29'h7FF, 1'b0, 1'b0, 5'd0), r);
        issue(make_op(MODE_REQUEST, 29'h7FF, 1'b1, 1'b0, 5'd0), r);
        issue(make_op(MODE_FINISH, 29'h0, 1'b0, 1'b0, 5'd17), r);
        issue(make_op(MODE_REQUEST, 29'h0, 1'b0, 1'b0, 5'd0), r);
        issue(make_op(MODE_LOAD, 29'h15555555, 1'b1, 1'b0, 5'd30), r);
        issue(make_op(MODE_LOAD, 29'h0AAAAAAA, 1'b1, 1'b0, 5'd31), r);
        issue(make_op(MODE_MUTE, 29'h0, 1'b0, 1'b0, 5'd31), r);
        issue(make_op(MODE_REQUEST, 29'h0, 1'b0, 1'b0, 5'd0), r);

        run_random(80);
        // shrink the count while the top pointer may sit above the last mailbox
        set_app_count(4'd2);
        run_random(60);
        set_app_count(4'd0);
        run_random(50);
        set_app_count(4'd1);
        run_random(50);
        set_app_count(4'd15);
        steady = 1'b1;
        run_random(90);
        drain();
        steady = 1'b0;
        set_app_count(4'd8);
        run_random(90);

        drain();
        repeat (40) @(posedge aclk);
        if (expected_grants.size() != 0)
            report_mismatch("results never delivered", 0, expected_grants.size());
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

FILE: can_tx_mailbox_allocator.f
hdl/cantx_pkg.sv
hdl/can_tx_mailbox_allocator.sv
sim/can_tx_mailbox_allocator_test.sv
